[rtl/core/allele_frequency_counter_macros.svh]
// Assertion macros shared by the allele frequency counter RTL.
`ifndef ALLELE_FREQUENCY_COUNTER_MACROS_SVH
`define ALLELE_FREQUENCY_COUNTER_MACROS_SVH

// Same-cycle implication, clocked on clk, off during rst.
`define AFC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allele_frequency_counter: assertion failed");

// Next-cycle implication, clocked on clk, off during rst.
`define AFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allele_frequency_counter: assertion failed");

`endif

[rtl/core/afc_pkg.sv]
// Shared constants and types for the allele frequency counter.
`default_nettype none
package afc_pkg;

  localparam int MAX_SAMPLES   = 65536;
  localparam int FRACTION_BITS = 16;

  localparam int COUNT_W = 18;
  localparam int TOTAL_W = COUNT_W + 1;
  localparam int FREQ_W  = FRACTION_BITS + 1;
  localparam int REM_W   = TOTAL_W + 1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(2 * MAX_SAMPLES);
  localparam logic [FREQ_W-1:0]  FREQ_ONE  = FREQ_W'(1) << FRACTION_BITS;

  localparam int DIV_STEPS = FREQ_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [2:0] GT_HOM_REF = 3'd0;
  localparam logic [2:0] GT_HET     = 3'd1;
  localparam logic [2:0] GT_HOM_ALT = 3'd2;

  localparam logic [1:0] SEX_MALE   = 2'd1;
  localparam logic [1:0] SEX_FEMALE = 2'd2;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

[rtl/core/afc_divider.sv]
// Restoring divider producing one quotient bit per cycle for the frequency.
`default_nettype none
module afc_divider (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire afc_pkg::div_ctrl_t            ctrl,
  input  wire logic [afc_pkg::COUNT_W-1:0]   numer,
  input  wire logic [afc_pkg::TOTAL_W-1:0]   denom,
  output afc_pkg::div_stat_t                 stat,
  output logic [afc_pkg::FREQ_W-1:0]         quotient
);

  logic                          running;
  logic                          done;
  logic [afc_pkg::STEP_W-1:0]    step;
  logic [afc_pkg::REM_W-1:0]     rem;
  logic [afc_pkg::TOTAL_W-1:0]   den;
  logic [afc_pkg::FREQ_W-1:0]    quo;

  logic                          fits;
  logic [afc_pkg::REM_W-1:0]     diff;
  logic [afc_pkg::REM_W-1:0]     kept;

  always_comb begin
    fits = rem >= {1'b0, den};
    diff = rem - {1'b0, den};
    kept = fits ? diff : rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else if (ctrl.start) begin
      running <= 1'b1;
      done    <= 1'b0;
      step    <= '0;
    end else if (running) begin
      step <= step + 1'b1;
      if (step == afc_pkg::STEP_W'(afc_pkg::DIV_STEPS - 1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem <= {{(afc_pkg::REM_W - afc_pkg::COUNT_W){1'b0}}, numer};
      den <= denom;
      quo <= '0;
    end else if (running) begin
      rem <= {kept[afc_pkg::REM_W-2:0], 1'b0};
      quo <= {quo[afc_pkg::FREQ_W-2:0], fits};
    end
  end

  assign stat.busy = running;
  assign stat.done = done;
  assign quotient  = quo;

endmodule
`default_nettype wire

[rtl/core/allele_frequency_counter.sv]
// Allele frequency counter top level: allele accumulation and result sequencing.
// Input channel (in_valid/in_ready) carries one sample genotype per item with
// sex, an X chromosome flag and a last-sample mark. Each item is accepted and
// added to saturating reference and alternative allele counts.
// Throughput: one sample item per cycle while the block is idle.
// An item marked last closes the SNP: in_ready drops while the restoring
// divider forms ref*2^16/(ref+alt), one quotient bit per cycle.
// The result enters the output register once the divider is done and the output
// register is free, and the block takes samples again in the cycle after that.
// A SNP with no counted alleles gives no_data with a zero frequency through the
// same path.
// Output channel (out_valid/out_ready) holds one result in a register; samples
// are still accepted while it waits. If the receiver stalls when a new result
// is finished, the divider holds it and in_ready stays low until the old result
// is taken.
// Reset (rst, synchronous) clears both counts, the sequencer and out_valid.
`default_nettype none
`include "allele_frequency_counter_macros.svh"
module allele_frequency_counter (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [2:0]             genotype,
  input  wire logic [1:0]                    sex,
  input  wire logic                          is_x_chromosome,
  input  wire logic                          last_sample,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [afc_pkg::FREQ_W-1:0]         ref_frequency,
  output logic                               no_data,
  output logic [afc_pkg::COUNT_W-1:0]        ref_total,
  output logic [afc_pkg::COUNT_W-1:0]        alt_total
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic                          state;
  logic                          state_next;
  logic [afc_pkg::COUNT_W-1:0]   ref_count;
  logic [afc_pkg::COUNT_W-1:0]   alt_count;
  logic [afc_pkg::COUNT_W-1:0]   ref_hold;
  logic [afc_pkg::COUNT_W-1:0]   alt_hold;
  logic                          zero_hold;

  logic                          accept;
  logic                          close;
  logic                          load;
  logic [2:0]                    gt;
  logic [1:0]                    add_ref;
  logic [1:0]                    add_alt;
  logic [afc_pkg::COUNT_W-1:0]   ref_sum;
  logic [afc_pkg::COUNT_W-1:0]   alt_sum;
  logic [afc_pkg::COUNT_W-1:0]   ref_new;
  logic [afc_pkg::COUNT_W-1:0]   alt_new;
  logic [afc_pkg::TOTAL_W-1:0]   total_new;

  afc_pkg::div_ctrl_t            div_ctrl;
  afc_pkg::div_stat_t            div_stat;
  logic [afc_pkg::FREQ_W-1:0]    div_quo;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign close    = accept && last_sample;
  assign gt       = $unsigned(genotype);

  always_comb begin
    add_ref = 2'd0;
    add_alt = 2'd0;
    if (!is_x_chromosome || sex == afc_pkg::SEX_FEMALE) begin
      case (gt)
        afc_pkg::GT_HOM_REF: add_ref = 2'd2;
        afc_pkg::GT_HET: begin
          add_ref = 2'd1;
          add_alt = 2'd1;
        end
        afc_pkg::GT_HOM_ALT: add_alt = 2'd2;
        default: ;
      endcase
    end else if (sex == afc_pkg::SEX_MALE) begin
      case (gt)
        afc_pkg::GT_HOM_REF: add_ref = 2'd1;
        afc_pkg::GT_HOM_ALT: add_alt = 2'd1;
        default: ;
      endcase
    end
  end

  always_comb begin
    ref_sum   = ref_count + afc_pkg::COUNT_W'(add_ref);
    alt_sum   = alt_count + afc_pkg::COUNT_W'(add_alt);
    ref_new   = (ref_sum > afc_pkg::COUNT_MAX) ? afc_pkg::COUNT_MAX : ref_sum;
    alt_new   = (alt_sum > afc_pkg::COUNT_MAX) ? afc_pkg::COUNT_MAX : alt_sum;
    total_new = {1'b0, ref_new} + {1'b0, alt_new};
  end

  assign div_ctrl.start = close;

  afc_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .numer    (ref_new),
    .denom    (total_new),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  assign load = (state == ST_DIV) && div_stat.done && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (close) state_next = ST_DIV;
      ST_DIV:  if (load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ref_count <= '0;
      alt_count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        ref_count <= last_sample ? '0 : ref_new;
        alt_count <= last_sample ? '0 : alt_new;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (close) begin
      ref_hold  <= ref_new;
      alt_hold  <= alt_new;
      zero_hold <= (total_new == '0);
    end
    if (load) begin
      ref_frequency <= zero_hold ? '0 : div_quo;
      no_data       <= zero_hold;
      ref_total     <= ref_hold;
      alt_total     <= alt_hold;
    end
  end

  `AFC_ASSERT_NEXT(a_close_enters_div, close, (state == ST_DIV) && !in_ready)
  `AFC_ASSERT_NEXT(a_close_starts_divider, close, div_stat.busy)
  `AFC_ASSERT_NEXT(a_close_clears_counts, close, (ref_count == '0) && (alt_count == '0))
  `AFC_ASSERT_IMP(a_counts_bounded, 1'b1,
    (ref_count <= afc_pkg::COUNT_MAX) && (alt_count <= afc_pkg::COUNT_MAX))
  `AFC_ASSERT_IMP(a_no_data_empty, out_valid && no_data,
    (ref_frequency == '0) && (ref_total == '0) && (alt_total == '0))
  `AFC_ASSERT_IMP(a_freq_bounded, out_valid && !no_data, ref_frequency <= afc_pkg::FREQ_ONE)

endmodule
`default_nettype wire
